### hw/rtl/rotary_knob_input_controller_assert.svh
// Assertion macros for the knob controller checker.
// No dependencies; included by files that assert.
`ifndef ROTARY_KNOB_INPUT_CONTROLLER_ASSERT_SVH
`define ROTARY_KNOB_INPUT_CONTROLLER_ASSERT_SVH

// Antecedent holds in this cycle, consequent holds in the same cycle.
`define RKI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent holds in this cycle, consequent holds in the next cycle.
`define RKI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/rki_pkg.sv
// Package for the rotary knob input controller: widths, codes, types, helpers.
// No dependencies; imported by rki_debounce and rotary_knob_input_controller.
package rki_pkg;

    localparam int RKI_SWITCH_COUNT = 3;

    localparam int SW_LEFT  = 0;
    localparam int SW_SHIFT = 1;
    localparam int SW_RIGHT = 2;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_LIMIT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COARSE_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FINE_THRESHOLD   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_MAX        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCUM_SHIFT      = 3'd4;

    localparam logic [7:0]  DEBOUNCE_LIMIT_RST   = 8'd8;
    localparam logic [10:0] COARSE_THRESHOLD_RST = 11'd128;
    localparam logic [10:0] FINE_THRESHOLD_RST   = 11'd4;
    localparam logic [6:0]  SPEED_MAX_RST        = 7'd16;
    localparam logic [3:0]  ACCUM_SHIFT_RST      = 4'd7;
    localparam logic [6:0]  GAIN_RST             = 7'd8;

    // consumer tap codes
    localparam logic [2:0] CP_NONE     = 3'd0;
    localparam logic [2:0] CP_VOL_UP   = 3'd1;
    localparam logic [2:0] CP_VOL_DOWN = 3'd2;
    localparam logic [2:0] CP_NEXT     = 3'd3;
    localparam logic [2:0] CP_PREV     = 3'd4;

    // consumer hold codes
    localparam logic [1:0] CH_NONE        = 2'd0;
    localparam logic [1:0] CH_MUTE        = 2'd1;
    localparam logic [1:0] CH_PLAY_PAUSE  = 2'd2;
    localparam logic [1:0] CH_RELEASE_ALL = 2'd3;

    typedef enum logic [1:0] {
        MODE_SCROLL = 2'd0,
        MODE_PAN    = 2'd1,
        MODE_VOLUME = 2'd2
    } mode_t;

    // per-switch debounce result for the current transfer
    typedef struct packed {
        logic press;
        logic release_ev;
        logic stable;
    } sw_event_t;

    function automatic logic [15:0] asr16(input logic [15:0] v, input logic [3:0] s);
        return 16'($signed(v) >>> s);
    endfunction

endpackage

### hw/rtl/rki_debounce.sv
// One switch debouncer: saturating up/down counter with press/release events.
// Depends on rki_pkg.
module rki_debounce
    import rki_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       prime,      // load stable level, clear counter
    input  logic       step,       // debounce one poll
    input  logic       level,      // raw level, 1 released
    input  logic [7:0] limit,
    output sw_event_t  ev
);

    logic [7:0] count_reg, count_next;
    logic       stable_reg;

    always_comb begin
        count_next = count_reg;
        if (level) begin
            if (count_reg < limit) count_next = count_reg + 8'd1;
        end else begin
            if (count_reg != 8'd0) count_next = count_reg - 8'd1;
        end
        ev.press      = stable_reg && (count_next == 8'd0);
        ev.release_ev = !stable_reg && (count_next == limit);
        ev.stable     = (stable_reg && (count_next != 8'd0)) || (count_next == limit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 8'd0;
        end else if (prime) begin
            count_reg <= 8'd0;
        end else if (step) begin
            count_reg <= count_next;
        end
    end

    // stable level is loaded by the priming poll
    always_ff @(posedge aclk) begin
        if (prime) begin
            stable_reg <= level;
        end else if (step) begin
            stable_reg <= ev.stable;
        end
    end

endmodule

### hw/rtl/rotary_knob_input_controller.sv
// Rotary knob input controller: switch debouncing, angle hysteresis, mode and actions.
// Each accepted input transfer loads its result into the output register.
// Throughput: one item per cycle while the output is not stalled; a new item is taken while the result is taken.
// Reset (synchronous, aresetn low): registers to defaults, gains 8, mode scroll,
// accumulators zero, output empty; the first item after reset primes the state.
// Depends on rki_pkg and rki_debounce.
module rotary_knob_input_controller
    import rki_pkg::*;
#(
    parameter int SWITCH_COUNT = RKI_SWITCH_COUNT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // tdata from bit 0: left_switch, shift_switch, right_switch, raw_angle[11:0]
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // tdata from bit 0: knob_mode_out[1:0], vertical_scroll[7:0],
    // horizontal_scroll[7:0], wheel_press, wheel_release, wiggle_toggle,
    // consumer_pulse[2:0], consumer_hold[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [7:0]  debounce_limit_reg;
    logic [10:0] coarse_thr_reg;
    logic [10:0] fine_thr_reg;
    logic [6:0]  speed_max_reg;
    logic [3:0]  accum_shift_reg;

    logic [15:0] coarse_pos_reg, fine_pos_reg;
    mode_t       mode_reg, mode_next;
    logic [6:0]  scroll_gain_reg, pan_gain_reg, gain_next;
    logic [15:0] accum_reg, accum_last_reg, accum_next;
    logic        primed_reg;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic accept, prime, step;
    sw_event_t ev [SWITCH_COUNT];

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign prime     = accept && !primed_reg;
    assign step      = accept && primed_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    for (genvar i = 0; i < SWITCH_COUNT; i++) begin : g_sw
        rki_debounce u_deb (
            .aclk    (aclk),
            .aresetn (aresetn),
            .prime   (prime),
            .step    (step),
            .level   (s_tdata[i]),
            .limit   (debounce_limit_reg),
            .ev      (ev[i])
        );
    end

    logic [15:0] raw, cdiff, fdiff, fdelta_s, fdelta;
    logic [16:0] c_lim, f_lim;
    logic        c_hit, f_hit, inc, dec, released;
    logic [2:0]  m_step;
    logic        panning;
    logic [6:0]  gain_sel;
    logic signed [8:0] gain_adj;
    logic [22:0] prod;
    logic [15:0] sdiff;
    logic [7:0]  vs, hs;
    logic        wp, wr, wt;
    logic [2:0]  cp;
    logic [1:0]  ch;
    logic        move_upd, gain_upd;

    always_comb begin
        raw = {s_tdata[14:3], 4'b0000};

        cdiff = raw - coarse_pos_reg;
        c_lim = {2'b00, coarse_thr_reg, 4'b0000};
        c_hit = ($signed({cdiff[15], cdiff}) > $signed(c_lim)) ||
                ($signed({cdiff[15], cdiff}) < $signed(17'(17'd0 - c_lim)));
        inc   = c_hit && !cdiff[15];
        dec   = c_hit && cdiff[15];

        fdiff    = raw - fine_pos_reg;
        fdelta_s = asr16(fdiff, 4'd4);
        f_lim    = {6'b0, fine_thr_reg};
        f_hit    = ($signed({fdelta_s[15], fdelta_s}) > $signed(f_lim)) ||
                   ($signed({fdelta_s[15], fdelta_s}) < $signed(17'(17'd0 - f_lim)));
        fdelta   = f_hit ? fdelta_s : 16'd0;

        released = ev[SW_SHIFT].stable;

        // left steps down, right steps up, wrap within three modes
        m_step = {1'b0, mode_reg} - {2'b00, ev[SW_LEFT].press} + {2'b00, ev[SW_RIGHT].press};
        mode_next = mode_reg;
        if (released) begin
            if (m_step[2]) mode_next = MODE_VOLUME;
            else if (m_step > 3'd2) mode_next = MODE_SCROLL;
            else mode_next = mode_t'(m_step[1:0]);
        end

        panning  = (mode_next == MODE_PAN);
        gain_sel = panning ? pan_gain_reg : scroll_gain_reg;

        // clamp low first, then high
        gain_adj = $signed({2'b00, gain_sel}) + $signed({8'd0, inc}) - $signed({8'd0, dec});
        if (gain_adj < 9'sd1) gain_adj = 9'sd1;
        if (gain_adj > $signed({2'b00, speed_max_reg})) gain_adj = $signed({2'b00, speed_max_reg});
        gain_next = gain_adj[6:0];

        prod       = fdelta * gain_sel;
        accum_next = accum_reg + prod[15:0];
        sdiff      = asr16(accum_last_reg, accum_shift_reg) - asr16(accum_next, accum_shift_reg);

        vs = 8'd0;
        hs = 8'd0;
        wp = 1'b0;
        wr = 1'b0;
        wt = 1'b0;
        cp = CP_NONE;
        ch = CH_NONE;
        move_upd = 1'b0;
        gain_upd = 1'b0;

        case (mode_next)
            MODE_SCROLL, MODE_PAN: begin
                if (released) begin
                    if (fdelta != 16'd0) begin
                        move_upd = 1'b1;
                        if (panning) hs = sdiff[7:0];
                        else vs = sdiff[7:0];
                    end
                end else begin
                    wt = ev[SW_RIGHT].press;
                    wp = ev[SW_LEFT].press;
                    gain_upd = 1'b1;
                end
                wr = ev[SW_LEFT].release_ev || ev[SW_RIGHT].release_ev;
            end
            MODE_VOLUME: begin
                if (released) begin
                    if (inc) cp = CP_VOL_UP;
                    if (dec) cp = CP_VOL_DOWN;
                end else begin
                    if (inc) cp = CP_NEXT;
                    if (dec) cp = CP_PREV;
                    if (ev[SW_LEFT].press) ch = CH_MUTE;
                    if (ev[SW_RIGHT].press) ch = CH_PLAY_PAUSE;
                end
                if (ev[SW_LEFT].release_ev || ev[SW_RIGHT].release_ev) ch = CH_RELEASE_ALL;
            end
            default: begin
            end
        endcase

        if (primed_reg) begin
            m_tdata_next = {6'd0, ch, cp, wt, wr, wp, hs, vs, mode_next};
        end else begin
            m_tdata_next = {30'd0, mode_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_limit_reg <= DEBOUNCE_LIMIT_RST;
            coarse_thr_reg     <= COARSE_THRESHOLD_RST;
            fine_thr_reg       <= FINE_THRESHOLD_RST;
            speed_max_reg      <= SPEED_MAX_RST;
            accum_shift_reg    <= ACCUM_SHIFT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DEBOUNCE_LIMIT:   debounce_limit_reg <= cfg_data[7:0];
                CFG_COARSE_THRESHOLD: coarse_thr_reg     <= cfg_data[10:0];
                CFG_FINE_THRESHOLD:   fine_thr_reg       <= cfg_data[10:0];
                CFG_SPEED_MAX:        speed_max_reg      <= cfg_data[6:0];
                CFG_ACCUM_SHIFT:      accum_shift_reg    <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_SCROLL;
            scroll_gain_reg <= GAIN_RST;
            pan_gain_reg    <= GAIN_RST;
            accum_reg       <= 16'd0;
            accum_last_reg  <= 16'd0;
            primed_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (prime) begin
                primed_reg <= 1'b1;
            end
            if (step) begin
                mode_reg <= mode_next;
                if (move_upd) begin
                    accum_reg      <= accum_next;
                    accum_last_reg <= accum_next;
                end
                if (gain_upd) begin
                    if (panning) pan_gain_reg <= gain_next;
                    else scroll_gain_reg <= gain_next;
                end
            end
        end
    end

    // positions are loaded by the priming poll; result payload needs no reset
    always_ff @(posedge aclk) begin
        if (prime) begin
            coarse_pos_reg <= raw;
            fine_pos_reg   <= raw;
        end else if (step) begin
            if (c_hit) coarse_pos_reg <= raw;
            if (f_hit) fine_pos_reg <= raw;
        end
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

### hw/rtl/rki_checker.sv
// Port-level checker for the rotary knob input controller, bound to the top level.
// Depends on rotary_knob_input_controller_assert.svh.
`include "rotary_knob_input_controller_assert.svh"

module rki_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result holds
    `RKI_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // an empty output register never stalls the input
    `RKI_ASSERT_IMPLY(a_ready, aclk, aresetn, !m_tvalid, s_tready)
    // mode stays within the three modes
    `RKI_ASSERT_IMPLY(a_mode, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3)
    // vertical motion only in scroll mode
    `RKI_ASSERT_IMPLY(a_vs, aclk, aresetn, m_tvalid && (m_tdata[9:2] != 8'd0), m_tdata[1:0] == 2'd0)
    // consumer taps only in volume mode
    `RKI_ASSERT_IMPLY(a_cp, aclk, aresetn, m_tvalid && (m_tdata[23:21] != 3'd0), m_tdata[1:0] == 2'd2)

endmodule

bind rotary_knob_input_controller rki_checker u_rki_checker (.*);
